// ===== rtl/core/cpi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_pkg - curve point interpolator shared definitions
// fixed-point constants, field widths and port width helpers
// ----------------------------------------------------------------------------
package cpi_pkg;

   localparam int WORD_WIDTH_DEF = 32;   // default linear field width
   localparam int THETA_IN_W     = 32;   // heading in, q4.27
   localparam int THETA_OUT_W    = 30;   // wrapped heading out
   localparam int ANG_W          = 33;   // wrap accumulator
   localparam int DIG_W          = 16;   // multiplier digit width

   // pi and 2*pi in q4.27
   localparam logic [THETA_OUT_W-1:0] PI_Q     = 30'd421657428;
   localparam logic [THETA_OUT_W-1:0] TWO_PI_Q = 30'd843314856;

   // request word: seven fields, rounded up to whole bytes
   function automatic int req_data_width(input int w);
      return ((6 * w + THETA_IN_W + 7) >> 3) << 3;
   endfunction

   // response word: six fields, rounded up to whole bytes
   function automatic int rsp_data_width(input int w);
      return ((5 * w + THETA_OUT_W + 7) >> 3) << 3;
   endfunction

endpackage

// ===== rtl/core/curve_point_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// curve_point_interpolator - path point interpolation at a query arc length
// blends x, y, kappa and dkappa linearly and heading along the short arc,
// using one shared multiplier digit and one restoring divider
// ----------------------------------------------------------------------------
// a first-point word (tuser 0) is stored in the accept cycle, no result
// a second-point word wraps both headings, then runs setup, multiply, divide,
//   round and apply for each field before its result word is registered
// the divider retires one quotient bit per cycle and takes most of that time
// a failed word (s0 >= s1) skips the datapath and goes straight to the result
// reset: synchronous, clears the sequencer, the result valid and the first point
// ----------------------------------------------------------------------------
module curve_point_interpolator #(
   parameter int WORD_WIDTH = cpi_pkg::WORD_WIDTH_DEF,
   localparam int REQ_DW = cpi_pkg::req_data_width(WORD_WIDTH),
   localparam int RSP_DW = cpi_pkg::rsp_data_width(WORD_WIDTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // point_x, point_y, point_theta, point_kappa, point_dkappa, point_s, query_s
   input  logic [REQ_DW-1:0] req_tdata,
   // mode
   input  logic              req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // out_x, out_y, out_theta, out_kappa, out_dkappa, out_s
   output logic [RSP_DW-1:0] rsp_tdata,
   // failed
   output logic              rsp_tuser
);
   import cpi_pkg::*;

   localparam int W   = WORD_WIDTH;
   // operand magnitude: a linear difference or the heading difference
   localparam int AW  = (W > THETA_OUT_W) ? W : THETA_OUT_W;
   localparam int PW  = AW + W;                    // full product width
   localparam int ND  = (W + DIG_W - 1) / DIG_W;   // multiplier digits
   localparam int NPW = ND * DIG_W;
   // quotient register, wide enough for the heading modulus
   localparam int QW  = (W + 2 > THETA_OUT_W) ? W + 2 : THETA_OUT_W;
   localparam int SW  = QW + 2;                    // blend sum width
   localparam int CW  = $clog2(PW);

   localparam logic signed [ANG_W-1:0]     PI_A     = ANG_W'(PI_Q);
   localparam logic signed [ANG_W-1:0]     TWO_PI_A = ANG_W'(TWO_PI_Q);
   localparam logic signed [THETA_OUT_W:0] PI_D     = {1'b0, PI_Q};
   localparam logic signed [THETA_OUT_W:0] TWO_PI_D = {1'b0, TWO_PI_Q};
   localparam logic [QW:0]                 MOD_Q    = (QW+1)'(TWO_PI_Q);

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_WRAP  = 4'd1;
   localparam logic [3:0] ST_DIFF  = 4'd2;
   localparam logic [3:0] ST_SETUP = 4'd3;
   localparam logic [3:0] ST_MUL   = 4'd4;
   localparam logic [3:0] ST_DIV   = 4'd5;
   localparam logic [3:0] ST_FIN   = 4'd6;
   localparam logic [3:0] ST_APPLY = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   // field being blended, in result order
   localparam logic [2:0] FLD_X  = 3'd0;
   localparam logic [2:0] FLD_Y  = 3'd1;
   localparam logic [2:0] FLD_TH = 3'd2;
   localparam logic [2:0] FLD_K  = 3'd3;
   localparam logic [2:0] FLD_DK = 3'd4;

   // what the angle wrap loop is reducing
   localparam logic [1:0] WS_T0 = 2'd0;
   localparam logic [1:0] WS_T1 = 2'd1;
   localparam logic [1:0] WS_TH = 2'd2;

   // ---------------------------------------------------------------- input word
   logic signed [W-1:0]          in_x, in_y, in_k, in_dk, in_s, in_q;
   logic        [THETA_IN_W-1:0] in_th;

   assign in_x  = req_tdata[0 +: W];
   assign in_y  = req_tdata[W +: W];
   assign in_th = req_tdata[2*W +: THETA_IN_W];
   assign in_k  = req_tdata[2*W+THETA_IN_W +: W];
   assign in_dk = req_tdata[3*W+THETA_IN_W +: W];
   assign in_s  = req_tdata[4*W+THETA_IN_W +: W];
   assign in_q  = req_tdata[5*W+THETA_IN_W +: W];

   // ---------------------------------------------------------------- registers
   logic [3:0] st_ff, st_in;
   logic [1:0] wsel_ff, wsel_in;
   logic [2:0] fld_ff, fld_in;

   // stored first point (reset to zero)
   logic signed [W-1:0]          fp_x_ff, fp_x_in, fp_y_ff, fp_y_in;
   logic signed [W-1:0]          fp_k_ff, fp_k_in, fp_dk_ff, fp_dk_in;
   logic signed [W-1:0]          fp_s_ff, fp_s_in;
   logic        [THETA_IN_W-1:0] fp_th_ff, fp_th_in;

   // second point, held for the whole item
   logic signed [W-1:0]          p1_x_ff, p1_x_in, p1_y_ff, p1_y_in;
   logic signed [W-1:0]          p1_k_ff, p1_k_in, p1_dk_ff, p1_dk_in;
   logic        [THETA_IN_W-1:0] p1_th_ff, p1_th_in;

   // weight numerator (sign and magnitude) and denominator
   logic                 num_neg_ff, num_neg_in;
   logic [W-1:0]         num_mag_ff, num_mag_in;
   logic [W-1:0]         den_ff, den_in;

   // headings as wrapped angle plus pi, in [0, 2pi)
   logic [THETA_OUT_W-1:0]        t0p_ff, t0p_in, t1p_ff, t1p_in;
   logic signed [THETA_OUT_W:0]   d_ff, d_in;
   logic signed [ANG_W-1:0]       ang_ff, ang_in;

   // shared multiply / divide datapath
   logic [AW-1:0]  a_ff, a_in;
   logic           neg_ff, neg_in;
   logic [PW-1:0]  acc_ff, acc_in;
   logic [NPW-1:0] nsh_ff, nsh_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [W-1:0]   rem_ff, rem_in;
   logic [QW-1:0]  q_ff, q_in;
   logic           big_ff, big_in;

   // result being built
   logic signed [W-1:0]           res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic signed [W-1:0]           res_k_ff, res_k_in, res_dk_ff, res_dk_in;
   logic signed [W-1:0]           res_s_ff, res_s_in;
   logic signed [THETA_OUT_W-1:0] res_th_ff, res_th_in;
   logic                          res_fail_ff, res_fail_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DW-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_fail_ff, rsp_fail_in;

   // ---------------------------------------------------------------- datapath
   logic                req_accept;
   logic                order_bad;
   logic signed [W:0]   num_full, den_full;
   logic [W-1:0]        num_mag;

   assign req_tready = (st_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // s0 >= s1 means no valid weight
   assign order_bad = (fp_s_ff >= in_s);
   assign num_full  = $signed({in_q[W-1], in_q}) - $signed({fp_s_ff[W-1], fp_s_ff});
   assign den_full  = $signed({in_s[W-1], in_s}) - $signed({fp_s_ff[W-1], fp_s_ff});
   assign num_mag   = num_full[W] ? W'(~num_full + 1'b1) : num_full[W-1:0];

   // angle wrap: add pi, then fold into [0, 2pi) one step a cycle
   logic signed [ANG_W-1:0] ang_t0, ang_t1, ang_less_pi, ang_th, q_ang;

   assign ang_t0      = $signed({fp_th_ff[THETA_IN_W-1], fp_th_ff}) + PI_A;
   assign ang_t1      = $signed({p1_th_ff[THETA_IN_W-1], p1_th_ff}) + PI_A;
   assign ang_less_pi = ang_ff - PI_A;
   assign q_ang       = $signed({3'b000, q_ff[THETA_OUT_W-1:0]});
   assign ang_th      = $signed({3'b000, t0p_ff}) + (neg_ff ? -q_ang : q_ang);

   // short-arc heading difference, exactly +pi or -pi is kept as it is
   logic signed [THETA_OUT_W:0] dd, d_adj;

   assign dd = $signed({1'b0, t1p_ff}) - $signed({1'b0, t0p_ff});

   always_comb begin
      if (dd > PI_D) begin
         d_adj = dd - TWO_PI_D;
      end else if (dd < -PI_D) begin
         d_adj = dd + TWO_PI_D;
      end else begin
         d_adj = dd;
      end
   end

   // endpoint values of the current field
   logic signed [W-1:0] v0, v1;

   always_comb begin
      case (fld_ff)
         FLD_X: begin
            v0 = fp_x_ff;
            v1 = p1_x_ff;
         end
         FLD_Y: begin
            v0 = fp_y_ff;
            v1 = p1_y_ff;
         end
         FLD_K: begin
            v0 = fp_k_ff;
            v1 = p1_k_ff;
         end
         default: begin
            v0 = fp_dk_ff;
            v1 = p1_dk_ff;
         end
      endcase
   end

   // operand: v1 - v0, or the heading difference
   logic signed [W:0]  dv;
   logic signed [AW:0] opd;
   logic [AW-1:0]      op_mag;

   assign dv     = $signed({v1[W-1], v1}) - $signed({v0[W-1], v0});
   assign opd    = (fld_ff == FLD_TH) ? (AW+1)'(d_ff) : (AW+1)'(dv);
   assign op_mag = opd[AW] ? AW'(~opd + 1'b1) : opd[AW-1:0];

   // one digit of the numerator per cycle, most significant first
   logic [DIG_W-1:0]    digit;
   logic [AW+DIG_W-1:0] prod;
   logic [PW-1:0]       acc_mul;

   assign digit   = nsh_ff[NPW-1 -: DIG_W];
   assign prod    = a_ff * digit;
   assign acc_mul = (acc_ff << DIG_W) + PW'(prod);

   // restoring divide step, one quotient bit per cycle
   logic [W:0]  r2, rsub;
   logic        div_ge;
   logic [QW:0] qsh, q_mod;

   assign r2     = {rem_ff, acc_ff[PW-1]};
   assign rsub   = r2 - {1'b0, den_ff};
   assign div_ge = (r2 >= {1'b0, den_ff});
   assign qsh    = {q_ff, div_ge};
   assign q_mod  = (qsh >= MOD_Q) ? (qsh - MOD_Q) : qsh;

   // round to nearest, ties away from zero
   logic        rnd;
   logic [QW:0] qr;

   assign rnd = ({rem_ff, 1'b0} >= {1'b0, den_ff});
   assign qr  = {1'b0, q_ff} + QW'(rnd);

   // blend and saturate
   logic signed [SW-1:0] qz, sum;
   logic                 ovf;
   logic signed [W-1:0]  sat;

   assign qz  = $signed({2'b00, q_ff});
   assign sum = SW'(v0) + (neg_ff ? -qz : qz);
   assign ovf = !((&sum[SW-1:W-1]) || !(|sum[SW-1:W-1]));

   always_comb begin
      if (big_ff) begin
         sat = neg_ff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else if (ovf) begin
         sat = sum[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         sat = sum[W-1:0];
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      st_in       = st_ff;
      wsel_in     = wsel_ff;
      fld_in      = fld_ff;
      fp_x_in     = fp_x_ff;
      fp_y_in     = fp_y_ff;
      fp_th_in    = fp_th_ff;
      fp_k_in     = fp_k_ff;
      fp_dk_in    = fp_dk_ff;
      fp_s_in     = fp_s_ff;
      p1_x_in     = p1_x_ff;
      p1_y_in     = p1_y_ff;
      p1_th_in    = p1_th_ff;
      p1_k_in     = p1_k_ff;
      p1_dk_in    = p1_dk_ff;
      num_neg_in  = num_neg_ff;
      num_mag_in  = num_mag_ff;
      den_in      = den_ff;
      t0p_in      = t0p_ff;
      t1p_in      = t1p_ff;
      d_in        = d_ff;
      ang_in      = ang_ff;
      a_in        = a_ff;
      neg_in      = neg_ff;
      acc_in      = acc_ff;
      nsh_in      = nsh_ff;
      cnt_in      = cnt_ff;
      rem_in      = rem_ff;
      q_in        = q_ff;
      big_in      = big_ff;
      res_x_in    = res_x_ff;
      res_y_in    = res_y_ff;
      res_th_in   = res_th_ff;
      res_k_in    = res_k_ff;
      res_dk_in   = res_dk_ff;
      res_s_in    = res_s_ff;
      res_fail_in = res_fail_ff;
      rsp_data_in = rsp_data_ff;
      rsp_fail_in = rsp_fail_ff;
      // a taken result word drops valid unless a new one loads below
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (st_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (!req_tuser) begin
                  // first point
                  fp_x_in  = in_x;
                  fp_y_in  = in_y;
                  fp_th_in = in_th;
                  fp_k_in  = in_k;
                  fp_dk_in = in_dk;
                  fp_s_in  = in_s;
               end else begin
                  p1_x_in     = in_x;
                  p1_y_in     = in_y;
                  p1_th_in    = in_th;
                  p1_k_in     = in_k;
                  p1_dk_in    = in_dk;
                  num_neg_in  = num_full[W];
                  num_mag_in  = num_mag;
                  den_in      = den_full[W-1:0];
                  ang_in      = ang_t0;
                  wsel_in     = WS_T0;
                  res_s_in    = in_q;
                  res_fail_in = 1'b0;
                  if (order_bad) begin
                     // all-zero point, failed flag set
                     res_x_in    = '0;
                     res_y_in    = '0;
                     res_th_in   = '0;
                     res_k_in    = '0;
                     res_dk_in   = '0;
                     res_s_in    = '0;
                     res_fail_in = 1'b1;
                     st_in       = ST_DONE;
                  end else begin
                     st_in = ST_WRAP;
                  end
               end
            end
         end

         ST_WRAP: begin
            if (ang_ff[ANG_W-1]) begin
               ang_in = ang_ff + TWO_PI_A;
            end else if (ang_ff >= TWO_PI_A) begin
               ang_in = ang_ff - TWO_PI_A;
            end else begin
               case (wsel_ff)
                  WS_T0: begin
                     t0p_in  = ang_ff[THETA_OUT_W-1:0];
                     ang_in  = ang_t1;
                     wsel_in = WS_T1;
                  end
                  WS_T1: begin
                     t1p_in = ang_ff[THETA_OUT_W-1:0];
                     st_in  = ST_DIFF;
                  end
                  default: begin
                     // blended heading done, back to the linear fields
                     res_th_in = ang_less_pi[THETA_OUT_W-1:0];
                     fld_in    = FLD_K;
                     st_in     = ST_SETUP;
                  end
               endcase
            end
         end

         ST_DIFF: begin
            d_in   = d_adj;
            fld_in = FLD_X;
            st_in  = ST_SETUP;
         end

         ST_SETUP: begin
            a_in   = op_mag;
            neg_in = opd[AW] ^ num_neg_ff;
            acc_in = '0;
            nsh_in = NPW'(num_mag_ff);
            cnt_in = '0;
            st_in  = ST_MUL;
         end

         ST_MUL: begin
            acc_in = acc_mul;
            nsh_in = nsh_ff << DIG_W;
            if (cnt_ff == CW'(ND - 1)) begin
               cnt_in = '0;
               rem_in = '0;
               q_in   = '0;
               big_in = 1'b0;
               st_in  = ST_DIV;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_DIV: begin
            acc_in = acc_ff << 1;
            rem_in = div_ge ? rsub[W-1:0] : r2[W-1:0];
            if (fld_ff == FLD_TH) begin
               // heading quotient is kept modulo 2pi
               q_in = q_mod[QW-1:0];
            end else begin
               // sticky overflow: the blend saturates anyway
               q_in   = qsh[QW-1:0];
               big_in = big_ff | q_ff[QW-1];
            end
            if (cnt_ff == CW'(PW - 1)) begin
               st_in = ST_FIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_FIN: begin
            if (fld_ff == FLD_TH) begin
               q_in = (qr == MOD_Q) ? '0 : qr[QW-1:0];
            end else begin
               q_in   = qr[QW-1:0];
               big_in = big_ff | qr[QW];
            end
            st_in = ST_APPLY;
         end

         ST_APPLY: begin
            if (fld_ff == FLD_TH) begin
               ang_in  = ang_th;
               wsel_in = WS_TH;
               st_in   = ST_WRAP;
            end else begin
               case (fld_ff)
                  FLD_X:   res_x_in  = sat;
                  FLD_Y:   res_y_in  = sat;
                  FLD_K:   res_k_in  = sat;
                  default: res_dk_in = sat;
               endcase
               fld_in = fld_ff + 1'b1;
               st_in  = (fld_ff == FLD_DK) ? ST_DONE : ST_SETUP;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = RSP_DW'({res_s_ff, res_dk_ff, res_k_ff, res_th_ff,
                                       res_y_ff, res_x_ff});
               rsp_fail_in  = res_fail_ff;
               rsp_valid_in = 1'b1;
               st_in        = ST_IDLE;
            end
         end

         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // control and stored first point
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fp_x_ff      <= '0;
         fp_y_ff      <= '0;
         fp_th_ff     <= '0;
         fp_k_ff      <= '0;
         fp_dk_ff     <= '0;
         fp_s_ff      <= '0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         fp_x_ff      <= fp_x_in;
         fp_y_ff      <= fp_y_in;
         fp_th_ff     <= fp_th_in;
         fp_k_ff      <= fp_k_in;
         fp_dk_ff     <= fp_dk_in;
         fp_s_ff      <= fp_s_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      wsel_ff     <= wsel_in;
      fld_ff      <= fld_in;
      p1_x_ff     <= p1_x_in;
      p1_y_ff     <= p1_y_in;
      p1_th_ff    <= p1_th_in;
      p1_k_ff     <= p1_k_in;
      p1_dk_ff    <= p1_dk_in;
      num_neg_ff  <= num_neg_in;
      num_mag_ff  <= num_mag_in;
      den_ff      <= den_in;
      t0p_ff      <= t0p_in;
      t1p_ff      <= t1p_in;
      d_ff        <= d_in;
      ang_ff      <= ang_in;
      a_ff        <= a_in;
      neg_ff      <= neg_in;
      acc_ff      <= acc_in;
      nsh_ff      <= nsh_in;
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      big_ff      <= big_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      res_th_ff   <= res_th_in;
      res_k_ff    <= res_k_in;
      res_dk_ff   <= res_dk_in;
      res_s_ff    <= res_s_in;
      res_fail_ff <= res_fail_in;
      rsp_data_ff <= rsp_data_in;
      rsp_fail_ff <= rsp_fail_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_fail_ff;

endmodule

// ===== rtl/core/cpi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_checker - port-level checks for the curve point interpolator
// watches both streams and flags behaviour the block must never show
// ----------------------------------------------------------------------------
module cpi_checker #(
   parameter int WORD_WIDTH = cpi_pkg::WORD_WIDTH_DEF,
   localparam int REQ_DW = cpi_pkg::req_data_width(WORD_WIDTH),
   localparam int RSP_DW = cpi_pkg::rsp_data_width(WORD_WIDTH)
) (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [REQ_DW-1:0] req_tdata,
   input logic              req_tuser,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_DW-1:0] rsp_tdata,
   input logic              rsp_tuser
);
   import cpi_pkg::*;

   logic signed [THETA_OUT_W:0] th_w;
   logic                        req_word;

   assign th_w     = $signed({rsp_tdata[2*WORD_WIDTH+THETA_OUT_W-1],
                              rsp_tdata[2*WORD_WIDTH +: THETA_OUT_W]});
   assign req_word = req_tvalid && req_tready && (req_tdata == req_tdata);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // a failed word carries an all-zero point
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("failed result with nonzero fields");

   // heading stays in [-pi, pi)
   a_theta_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         th_w >= -$signed({1'b0, PI_Q}) && th_w < $signed({1'b0, PI_Q}))
      else $error("heading outside wrap range");

   // a first-point word never produces a result
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      req_word && !req_tuser && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result after first-point word");

   // the block is busy right after taking a second-point word
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_word && req_tuser |=> !req_tready)
      else $error("ready right after second-point word");

endmodule

bind curve_point_interpolator cpi_checker #(.WORD_WIDTH(WORD_WIDTH)) u_cpi_checker (.*);

// ===== tb/tb_curve_point_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_curve_point_interpolator - self-checking bench for the path point interpolator
// streams first-point loads and interpolation requests through the block, predicts
// every result word in 128-bit arithmetic and compares it field by field
// ----------------------------------------------------------------------------
module tb_curve_point_interpolator;

   localparam int W      = cpi_pkg::WORD_WIDTH_DEF;
   localparam int REQ_DW = cpi_pkg::req_data_width(W);
   localparam int RSP_DW = cpi_pkg::rsp_data_width(W);

   // tuser codes on the request side
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam int ITEM_TARGET  = 1500;
   localparam int LONG_STALL   = 2000;      // receiver hold-off, in cycles
   localparam int DRAIN_CYCLES = 400;       // quiet time left for stray output at the end
   localparam int CYCLE_LIMIT  = 3_000_000;

   // handy 32-bit corner values
   localparam logic [31:0] W_MIN   = 32'h8000_0000;
   localparam logic [31:0] W_MAX   = 32'h7fff_ffff;
   localparam logic [31:0] PI_WORD = 32'd421657428;
   localparam logic [31:0] HALF_PI = 32'd210828714;
   localparam logic [31:0] ONE_M   = 32'h0001_0000;   // 1.0 in q16.16

   // predictor constants, kept signed so the arithmetic stays signed
   localparam longint HALF_TURN = longint'(cpi_pkg::PI_Q);
   localparam longint FULL_TURN = longint'(cpi_pkg::TWO_PI_Q);
   localparam longint WORD_HI   = 64'sd2147483647;
   localparam longint WORD_LO   = -64'sd2147483648;
   localparam logic [127:0] QUOT_CAP = 128'd1 << 60;

   // request word, highest field first so that x sits in the lowest bits
   typedef struct packed {
      logic signed [W-1:0]                  query_s;
      logic signed [W-1:0]                  point_s;
      logic signed [W-1:0]                  dkappa;
      logic signed [W-1:0]                  kappa;
      logic signed [cpi_pkg::THETA_IN_W-1:0] theta;
      logic signed [W-1:0]                  y;
      logic signed [W-1:0]                  x;
   } req_fields_t;

   // response word, two pad bits on top to make whole bytes
   typedef struct packed {
      logic [RSP_DW-5*W-cpi_pkg::THETA_OUT_W-1:0] pad;
      logic signed [W-1:0]                        s;
      logic signed [W-1:0]                        dkappa;
      logic signed [W-1:0]                        kappa;
      logic signed [cpi_pkg::THETA_OUT_W-1:0]      theta;
      logic signed [W-1:0]                        y;
      logic signed [W-1:0]                        x;
   } rsp_fields_t;

   typedef struct packed {
      logic        mode;
      req_fields_t fields;
      logic [2:0]  gap;        // idle cycles ahead of this word
   } req_item_t;

   typedef struct packed {
      logic        failed;
      rsp_fields_t f;
   } point_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata  = '0;   // point_x, point_y, point_theta, point_kappa,
                                         // point_dkappa, point_s, query_s
   logic              req_tuser  = 1'b0; // mode
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;         // out_x, out_y, out_theta, out_kappa,
                                         // out_dkappa, out_s
   logic              rsp_tuser;         // failed

   curve_point_interpolator #(.WORD_WIDTH(W)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // shared bench state
   // ---------------------------------------------------------------------------
   req_item_t     pending_words[$];     // stimulus not yet offered
   point_result_t expected_points[$];   // predicted results, oldest first
   req_fields_t   held_point;           // bench copy of the stored first point
   req_item_t     offered;              // word currently on the request bus
   logic          gap_spent;
   int            hold_off;
   bit            sender_quiet;         // stretch with no sender idling
   int            items_queued;
   int            stall_asks;           // bumped to request a long receiver stall
   int            stalls_served;
   int            stall_left;
   int            rsp_wait;
   int            quiet_words;
   int            rsp_gap_draw;
   int            loads_accepted, queries_accepted;
   int            results_checked, failed_seen, mismatches;
   int            cycle_count;
   rsp_fields_t   got;
   point_result_t want;

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------

   // wrap a q4.27 angle into [-pi, pi)
   function automatic longint wrap_heading(longint a);
      longint r;
      r = (a + HALF_TURN) % FULL_TURN;
      if (r < 0) r += FULL_TURN;
      return r - HALF_TURN;
   endfunction

   // round(diff * num / den), ties away from zero; the magnitude is either reduced
   // modulo turn_mod (heading) or capped, which is plenty to force saturation later
   function automatic longint scaled_part(longint diff, longint num, longint den,
                                          longint turn_mod);
      logic [127:0] md, mn, prod, quo, rem;
      logic         neg;
      neg  = (diff < 0) != (num < 0);
      md   = (diff < 0) ? -diff : diff;
      mn   = (num < 0) ? -num : num;
      prod = md * mn;
      quo  = prod / den;
      rem  = prod % den;
      if (2 * rem >= den) quo = quo + 1;
      if (turn_mod != 0) quo = quo % turn_mod;
      else if (quo > QUOT_CAP) quo = QUOT_CAP;
      return neg ? -longint'(quo[62:0]) : longint'(quo[62:0]);
   endfunction

   function automatic logic signed [W-1:0] clamp_word(longint v);
      if (v > WORD_HI) v = WORD_HI;
      if (v < WORD_LO) v = WORD_LO;
      return W'(v);
   endfunction

   // result of a query word given the stored first point
   function automatic point_result_t interpolate_point(req_fields_t a, req_fields_t b);
      point_result_t r;
      longint s0, s1, num, den, t0, t1, turn;
      r  = '0;
      s0 = longint'(a.point_s);
      s1 = longint'(b.point_s);
      // arc lengths out of order: zero point, flag raised
      if (s0 >= s1) begin
         r.failed = 1'b1;
         return r;
      end
      num = longint'(b.query_s) - s0;
      den = s1 - s0;
      r.f.x      = clamp_word(longint'(a.x) +
                              scaled_part(longint'(b.x) - longint'(a.x), num, den, 0));
      r.f.y      = clamp_word(longint'(a.y) +
                              scaled_part(longint'(b.y) - longint'(a.y), num, den, 0));
      r.f.kappa  = clamp_word(longint'(a.kappa) +
                              scaled_part(longint'(b.kappa) - longint'(a.kappa), num, den, 0));
      r.f.dkappa = clamp_word(longint'(a.dkappa) +
                              scaled_part(longint'(b.dkappa) - longint'(a.dkappa), num, den, 0));
      // short arc; a difference of exactly -pi is left as it is
      t0   = wrap_heading(longint'(a.theta));
      t1   = wrap_heading(longint'(b.theta));
      turn = t1 - t0;
      if (turn > HALF_TURN) turn -= FULL_TURN;
      else if (turn < -HALF_TURN) turn += FULL_TURN;
      r.f.theta = cpi_pkg::THETA_OUT_W'(wrap_heading(t0 + scaled_part(turn, num, den,
                                                                      FULL_TURN)));
      r.f.s     = b.query_s;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic void queue_item(logic mode, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] th, logic [31:0] k, logic [31:0] dk,
                                      logic [31:0] s, logic [31:0] qs);
      req_item_t it;
      it.mode   = mode;
      it.fields = {qs, s, dk, k, th, y, x};
      it.gap    = sender_quiet ? 3'd0 : 3'($urandom_range(0, 4));
      pending_words.push_back(it);
      items_queued++;
   endfunction

   // mostly full-range words, with corners and small values mixed in
   function automatic logic [31:0] draw_word();
      longint v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0:       return W_MIN;
               1:       return W_MAX;
               2:       return '0;
               default: return '1;
            endcase
         end
         1, 2, 3: begin
            v = $urandom_range(0, 131072);
            return 32'(v - 65536);
         end
         default: return $urandom();
      endcase
   endfunction

   // well-formed load-then-query runs for the most part, plus stray queries and loads
   task automatic queue_random_items(int target);
      logic [31:0]     s0, s1, qs, th0, tmp;
      longint          span;
      longint unsigned r64;
      int              pick;
      while (items_queued < target) begin
         if ($urandom_range(0, 7) == 0) sender_quiet = !sender_quiet;
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            s0 = draw_word();
            s1 = draw_word();
            // keep the order increasing most of the time
            if ($signed(s0) > $signed(s1) && $urandom_range(0, 11) != 0) begin
               tmp = s0;
               s0  = s1;
               s1  = tmp;
            end
            th0 = draw_word();
            queue_item(MODE_LOAD, draw_word(), draw_word(), th0, draw_word(), draw_word(),
                       s0, draw_word());
            repeat ($urandom_range(1, 3)) begin
               span = longint'($signed(s1)) - longint'($signed(s0));
               if (span > 0 && $urandom_range(0, 9) < 7) begin
                  r64 = {$urandom(), $urandom()};
                  qs  = 32'(longint'($signed(s0)) + longint'(r64 % longint'(span + 1)));
               end else begin
                  qs = draw_word();
               end
               case ($urandom_range(0, 9))
                  0:       tmp = th0 + PI_WORD;   // opposite heading
                  1:       tmp = th0 - PI_WORD;
                  default: tmp = draw_word();
               endcase
               queue_item(MODE_QUERY, draw_word(), draw_word(), tmp, draw_word(),
                          draw_word(), s1, qs);
            end
         end else if (pick < 90) begin
            queue_item(MODE_QUERY, draw_word(), draw_word(), draw_word(), draw_word(),
                       draw_word(), draw_word(), draw_word());
         end else begin
            queue_item(MODE_LOAD, draw_word(), draw_word(), draw_word(), draw_word(),
                       draw_word(), draw_word(), draw_word());
         end
      end
   endtask

   // sender pause: nothing left to offer and every predicted word returned
   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_tvalid || expected_points.size() != 0);
   endtask

   task automatic compare_field(input string name, input logic signed [63:0] want_v,
                                input logic signed [63:0] got_v);
      if (got_v !== want_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result %0d: %s expected %0d, got %0d", results_checked, name,
                     want_v, got_v);
      end
   endtask

   // ---------------------------------------------------------------------------
   // request driver: applies each word's gap, holds the word until it is taken,
   // and runs the predictor on every accepted word
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_spent  <= 1'b0;
         hold_off   <= 0;
         held_point = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (offered.mode == MODE_LOAD) begin
               held_point = offered.fields;
               loads_accepted++;
            end else begin
               expected_points.push_back(interpolate_point(held_point, offered.fields));
               queries_accepted++;
            end
         end
         // bus free for the next word once the current one is taken
         if (!req_tvalid || req_tready) begin
            if (hold_off != 0) begin
               hold_off   <= hold_off - 1;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (!gap_spent && pending_words[0].gap != 0) begin
               hold_off   <= pending_words[0].gap - 1;
               gap_spent  <= 1'b1;
               req_tvalid <= 1'b0;
            end else begin
               offered = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= offered.fields;
               req_tuser  <= offered.mode;
               gap_spent  <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // result monitor: checks each taken word against the oldest prediction and
   // throttles rsp_tready, including the long stall on request
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready    <= 1'b0;
         rsp_wait      <= 0;
         stall_left    <= 0;
         stalls_served <= 0;
         quiet_words   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_points.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result word with nothing expected: %h / %b", rsp_tdata,
                           rsp_tuser);
            end else begin
               want = expected_points.pop_front();
               results_checked++;
               if (want.failed) failed_seen++;
               compare_field("out_x", want.f.x, got.x);
               compare_field("out_y", want.f.y, got.y);
               compare_field("out_theta", want.f.theta, got.theta);
               compare_field("out_kappa", want.f.kappa, got.kappa);
               compare_field("out_dkappa", want.f.dkappa, got.dkappa);
               compare_field("out_s", want.f.s, got.s);
               compare_field("failed", want.failed, rsp_tuser);
            end
         end
         if (stalls_served != stall_asks) begin
            stalls_served <= stalls_served + 1;
            stall_left    <= LONG_STALL;
            rsp_tready    <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= (stall_left == 1);
         end else if (rsp_tvalid && rsp_tready) begin
            // gap after this word, with occasional runs of back-to-back acceptance
            if (quiet_words != 0) begin
               quiet_words  <= quiet_words - 1;
               rsp_gap_draw = 0;
            end else begin
               rsp_gap_draw = $urandom_range(0, 4);
               if ($urandom_range(0, 15) == 0) quiet_words <= 24;
            end
            if (rsp_gap_draw != 0) begin
               rsp_tready <= 1'b0;
               rsp_wait   <= rsp_gap_draw - 1;
            end
         end else if (!rsp_tready) begin
            if (rsp_wait != 0) rsp_wait <= rsp_wait - 1;
            else rsp_tready <= 1'b1;
         end else if (!rsp_tvalid && $urandom_range(0, 49) == 0) begin
            // idle dips so that arriving words meet a low ready at random phases
            rsp_tready <= 1'b0;
            rsp_wait   <= $urandom_range(0, 3);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------
   initial begin
      cycle_count  = 0;
      items_queued = 0;
      stall_asks   = 0;
      sender_quiet = 1'b0;

      // directed words, queued before reset is released
      // query with no first point loaded, so the stored point is all zero
      queue_item(MODE_QUERY, 32'h0002_0000, -32'sd196608, HALF_PI, 32'h0100_0000,
                 -32'sd16777216, ONE_M, 32'h0000_8000);
      // equal arc lengths against the cleared point
      queue_item(MODE_QUERY, 32'h1234_5678, 32'h9abc_def0, PI_WORD, 32'd1, 32'd2, '0, '0);
      // corner first point, then queries at weight one, weight zero and mid span
      queue_item(MODE_LOAD, W_MIN, W_MAX, W_MAX, W_MIN, W_MAX, W_MIN, W_MAX);
      queue_item(MODE_QUERY, W_MAX, W_MIN, W_MIN, W_MAX, W_MIN, W_MAX, W_MAX);
      queue_item(MODE_QUERY, W_MAX, W_MIN, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN);
      queue_item(MODE_QUERY, W_MAX, W_MIN, W_MIN, W_MAX, W_MIN, W_MAX, '0);
      queue_item(MODE_QUERY, '1, '1, '1, '1, '1, W_MIN, '1);
      // zero first point at arc length zero
      queue_item(MODE_LOAD, '0, '0, '0, '0, '0, '0, '0);
      // huge extrapolation both ways: saturation and exact heading wrap
      queue_item(MODE_QUERY, W_MAX, W_MIN, PI_WORD, 32'd1, '1, 32'd1, W_MAX);
      queue_item(MODE_QUERY, W_MAX, W_MIN, HALF_PI, 32'd1, '1, 32'd1, W_MIN);
      // half weight: ties round away from zero, heading exactly pi apart
      queue_item(MODE_QUERY, 32'd1, '1, PI_WORD, 32'd3, -32'sd3, 32'd2, 32'd1);
      queue_item(MODE_QUERY, 32'd1, '1, -32'sd421657428, 32'd3, -32'sd3, 32'd2, 32'd1);
      // quarter turns that are pi apart the other way round
      queue_item(MODE_LOAD, 32'h0010_0000, 32'h0020_0000, HALF_PI, '0, '0,
                 32'h0064_0000, '0);
      queue_item(MODE_QUERY, 32'h0030_0000, -32'sd1048576, -32'sd210828714, 32'h0080_0000,
                 32'h0000_1000, 32'h00c8_0000, 32'h0096_0000);
      // headings far outside one turn, negative arc lengths, backward extrapolation
      queue_item(MODE_LOAD, -32'sd5, 32'd7, 32'd1264972289, -32'sd100, 32'd100,
                 -32'sd327680, '0);
      queue_item(MODE_QUERY, 32'd5, -32'sd7, -32'sd1264972284, 32'd100, -32'sd100,
                 32'h0005_0000, '0);
      queue_item(MODE_QUERY, 32'd5, -32'sd7, W_MIN, 32'd100, -32'sd100,
                 32'h0005_0000, -32'sd3276800);
      // second arc length below the first
      queue_item(MODE_QUERY, 32'd5, -32'sd7, W_MAX, 32'd100, -32'sd100,
                 -32'sd393216, '0);
      // same stored point reused once more, then a fresh all-ones load
      queue_item(MODE_QUERY, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX);
      queue_item(MODE_LOAD, '1, '1, '1, '1, '1, '1, '1);
      queue_item(MODE_QUERY, '0, '0, '0, '0, '0, '0, 32'h4000_0000);

      @(posedge clock);
      @(posedge clock);
      reset <= 1'b0;

      wait_until_drained();

      // first random batch
      queue_random_items(700);
      wait_until_drained();

      // receiver holds off while the sender keeps offering queries
      stall_asks++;
      sender_quiet = 1'b1;
      queue_item(MODE_LOAD, draw_word(), draw_word(), draw_word(), draw_word(), draw_word(),
                 -32'sd65536, '0);
      repeat (12)
         queue_item(MODE_QUERY, draw_word(), draw_word(), draw_word(), draw_word(),
                    draw_word(), 32'h0100_0000, draw_word());
      sender_quiet = 1'b0;
      wait_until_drained();

      // remaining random words, then let any stray output show up
      queue_random_items(ITEM_TARGET);
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d first-point loads and %0d interpolation requests",
               loads_accepted, queries_accepted);
      $display("%0d result words checked, %0d flagged as out of order, %0d mismatches",
               results_checked, failed_seen, mismatches);
      if (mismatches == 0 && expected_points.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/cpi_pkg.sv
rtl/core/curve_point_interpolator.sv
rtl/core/cpi_checker.sv
tb/tb_curve_point_interpolator.sv
